@@ rtl/rfae_pkg.sv @@
// ----------------------------------------------------------------------------
// rfae_pkg
// Shared types, widths and operation codes for the register file ALU executor.
// ----------------------------------------------------------------------------
package rfae_pkg;

  localparam int FUNC_W      = 4;
  localparam int IDX_W       = 5;
  localparam int DATA_W      = 32;
  localparam int SH_W        = 5;
  localparam int NUM_REGS_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] OP_LI   = 4'd0;
  localparam logic [FUNC_W-1:0] OP_ADD  = 4'd1;
  localparam logic [FUNC_W-1:0] OP_ADDI = 4'd2;
  localparam logic [FUNC_W-1:0] OP_SUB  = 4'd3;
  localparam logic [FUNC_W-1:0] OP_MUL  = 4'd4;
  localparam logic [FUNC_W-1:0] OP_AND  = 4'd5;
  localparam logic [FUNC_W-1:0] OP_OR   = 4'd6;
  localparam logic [FUNC_W-1:0] OP_ORI  = 4'd7;
  localparam logic [FUNC_W-1:0] OP_XOR  = 4'd8;
  localparam logic [FUNC_W-1:0] OP_SLL  = 4'd9;
  localparam logic [FUNC_W-1:0] OP_SRL  = 4'd10;
  localparam logic [FUNC_W-1:0] OP_READ = 4'd11;

  // decoded instruction as held in the queue
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic              dest_ok;
    logic              a_ok;
    logic              b_ok;
    logic [DATA_W-1:0] imm;
    logic [SH_W-1:0]   sh;
  } entry_t;

  // queue to back end handshake
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

@@ rtl/rfae_front.sv @@
// ----------------------------------------------------------------------------
// rfae_front
// Decodes an incoming instruction: normalizes the op, picks read ports and
// checks register indices against the file size.
// ----------------------------------------------------------------------------
module rfae_front #(
  parameter int NUM_REGS = rfae_pkg::NUM_REGS_DEF
) (
  input  logic [rfae_pkg::FUNC_W-1:0]        func,
  input  logic [rfae_pkg::IDX_W-1:0]         dest_reg,
  input  logic [rfae_pkg::IDX_W-1:0]         src_a,
  input  logic [rfae_pkg::IDX_W-1:0]         src_b,
  input  logic signed [rfae_pkg::DATA_W-1:0] immediate,
  input  logic [rfae_pkg::SH_W-1:0]          shift_amount,
  output rfae_pkg::entry_t                   entry
);

  logic is_read;

  always_comb begin
    is_read = func inside {[rfae_pkg::OP_READ : {rfae_pkg::FUNC_W{1'b1}}]};
    entry.op      = is_read ? rfae_pkg::OP_READ : func;
    entry.dest    = dest_reg;
    entry.addr_a  = is_read ? dest_reg : src_a;
    entry.addr_b  = src_b;
    entry.dest_ok = int'(dest_reg) < NUM_REGS;
    entry.a_ok    = is_read ? (int'(dest_reg) < NUM_REGS) : (int'(src_a) < NUM_REGS);
    entry.b_ok    = int'(src_b) < NUM_REGS;
    entry.imm     = immediate;
    entry.sh      = shift_amount;
  end

endmodule

@@ rtl/rfae_queue.sv @@
// ----------------------------------------------------------------------------
// rfae_queue
// Short FIFO of decoded instructions between front and back end.
// ----------------------------------------------------------------------------
module rfae_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfae_pkg::entry_t     push_data,
  input  logic                 pop,
  output rfae_pkg::entry_t     pop_data,
  output rfae_pkg::q_status_t  status
);

  localparam int DEPTH = rfae_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  rfae_pkg::entry_t store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = store_r[rd_ptr_r];
  assign status.valid = count_r != '0;
  assign status.full  = int'(count_r) == DEPTH;

endmodule

@@ rtl/rfae_back.sv @@
// ----------------------------------------------------------------------------
// rfae_back
// Register file, operand read stage, ALU with write-back forwarding, and
// result output register.
// ----------------------------------------------------------------------------
module rfae_back #(
  parameter int NUM_REGS = rfae_pkg::NUM_REGS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rfae_pkg::q_status_t                q_status,
  input  rfae_pkg::entry_t                   q_data,
  output logic                               q_pop,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfae_pkg::IDX_W-1:0]         out_reg_index,
  output logic signed [rfae_pkg::DATA_W-1:0] out_reg_value,
  output logic                               out_was_write
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DW = rfae_pkg::DATA_W;

  logic [DW-1:0] mem_r [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  rfae_pkg::entry_t e_r;
  logic          e_valid_r;
  logic [DW-1:0] rd_a_r, rd_b_r;
  logic          rd_a_ok_r, rd_b_ok_r;

  logic             fwd_valid_r;
  logic [rfae_pkg::IDX_W-1:0] fwd_idx_r;
  logic [DW-1:0]    fwd_data_r;

  logic [rfae_pkg::IDX_W-1:0] out_idx_r;
  logic [DW-1:0]    out_val_r;
  logic             out_wr_r;
  logic             out_valid_r;

  logic [AW-1:0] ra, rb, wa;
  logic          e_go;
  logic [DW-1:0] opa, opb, val;
  logic          wr;

  assign ra    = AW'(q_data.addr_a);
  assign rb    = AW'(q_data.addr_b);
  assign wa    = AW'(e_r.dest);
  assign e_go  = e_valid_r && (!out_valid_r || !out_stall);
  assign q_pop = q_status.valid && (!e_valid_r || e_go);

  // operands, with bypass of the most recent write
  always_comb begin
    opa = rd_a_ok_r ? rd_a_r : '0;
    opb = rd_b_ok_r ? rd_b_r : '0;
    if (fwd_valid_r && e_r.a_ok && fwd_idx_r == e_r.addr_a) begin
      opa = fwd_data_r;
    end
    if (fwd_valid_r && e_r.b_ok && fwd_idx_r == e_r.addr_b) begin
      opb = fwd_data_r;
    end
  end

  always_comb begin
    wr = 1'b1;
    case (e_r.op)
      rfae_pkg::OP_LI:   val = e_r.imm;
      rfae_pkg::OP_ADD:  val = opa + opb;
      rfae_pkg::OP_ADDI: val = opa + e_r.imm;
      rfae_pkg::OP_SUB:  val = opa - opb;
      rfae_pkg::OP_MUL:  val = opa * opb;
      rfae_pkg::OP_AND:  val = opa & opb;
      rfae_pkg::OP_OR:   val = opa | opb;
      rfae_pkg::OP_ORI:  val = opa | e_r.imm;
      rfae_pkg::OP_XOR:  val = opa ^ opb;
      rfae_pkg::OP_SLL:  val = opa << e_r.sh;
      rfae_pkg::OP_SRL:  val = DW'($signed(opa) >>> e_r.sh);
      default: begin
        val = opa;
        wr  = 1'b0;
      end
    endcase
    wr = wr && e_r.dest_ok;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_a_ok_r   <= 1'b0;
      rd_b_ok_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        e_valid_r <= 1'b1;
        rd_a_ok_r <= q_data.a_ok && vld_r[ra];
        rd_b_ok_r <= q_data.b_ok && vld_r[rb];
      end else if (e_go) begin
        e_valid_r <= 1'b0;
      end
      if (e_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (e_go && wr) begin
        vld_r[wa]   <= 1'b1;
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // payload and register file
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_r    <= q_data;
      rd_a_r <= mem_r[ra];
      rd_b_r <= mem_r[rb];
    end
    if (e_go) begin
      out_idx_r <= e_r.dest;
      out_val_r <= val;
      out_wr_r  <= wr;
    end
    if (e_go && wr) begin
      mem_r[wa]  <= val;
      fwd_idx_r  <= e_r.dest;
      fwd_data_r <= val;
    end
  end

  assign busy          = e_valid_r || out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_reg_index = out_idx_r;
  assign out_reg_value = out_val_r;
  assign out_was_write = out_wr_r;

endmodule

@@ rtl/register_file_alu_executor_unit.sv @@
// ----------------------------------------------------------------------------
// register_file_alu_executor_unit
// Integer ALU executing decoded instructions on a 32-bit register file.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid/in_stall, func..shift_amount   | in
//   result   | out_valid/out_stall, reg_index..write   | out
//
// One instruction per cycle sustained while out_stall is low. An input transfer
// passes the queue write, then operand read, then ALU into the output register.
// Throughput is set by the single register file write port and the ALU stage.
// Synchronous active-low reset clears all registers to zero via valid bits.
// out_stall holds the ALU stage; the two-entry queue then fills and raises
// in_stall.
// ----------------------------------------------------------------------------
module register_file_alu_executor_unit #(
  parameter int NUM_REGS = rfae_pkg::NUM_REGS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rfae_pkg::FUNC_W-1:0]        in_func,
  input  logic [rfae_pkg::IDX_W-1:0]         in_dest_reg,
  input  logic [rfae_pkg::IDX_W-1:0]         in_src_a,
  input  logic [rfae_pkg::IDX_W-1:0]         in_src_b,
  input  logic signed [rfae_pkg::DATA_W-1:0] in_immediate,
  input  logic [rfae_pkg::SH_W-1:0]          in_shift_amount,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfae_pkg::IDX_W-1:0]         out_reg_index,
  output logic signed [rfae_pkg::DATA_W-1:0] out_reg_value,
  output logic                               out_was_write
);

  rfae_pkg::entry_t    dec_entry;
  rfae_pkg::entry_t    q_data;
  rfae_pkg::q_status_t q_status;
  logic                push;
  logic                q_pop;
  logic                busy;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  rfae_front #(.NUM_REGS(NUM_REGS)) u_front (
    .func         (in_func),
    .dest_reg     (in_dest_reg),
    .src_a        (in_src_a),
    .src_b        (in_src_b),
    .immediate    (in_immediate),
    .shift_amount (in_shift_amount),
    .entry        (dec_entry)
  );

  rfae_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (dec_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  rfae_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reg_index (out_reg_index),
    .out_reg_value (out_reg_value),
    .out_was_write (out_was_write)
  );

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_transfer_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (q_status.valid || busy))
    else $error("accepted instruction lost");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_write) |-> (int'(out_reg_index) < NUM_REGS))
    else $error("write reported for index outside register file");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_status.valid)
    else $error("pop from empty queue");

endmodule

@@ dv/tb_register_file_alu_executor_unit.sv @@
// ----------------------------------------------------------------------------
// tb_register_file_alu_executor_unit
// Self-checking bench for the register file ALU executor. A scoreboard keeps
// its own copy of the register file, predicts the writeback of every accepted
// instruction and compares the result channel in order. A directed set of
// corner cases comes first, then random instructions, with random idling and
// stalling on both channels.
// ----------------------------------------------------------------------------
module tb_register_file_alu_executor_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W      = rfae_pkg::FUNC_W;
  localparam int IDX_W       = rfae_pkg::IDX_W;
  localparam int DATA_W      = rfae_pkg::DATA_W;
  localparam int SH_W        = rfae_pkg::SH_W;
  localparam int NREGS       = rfae_pkg::NUM_REGS_DEF;
  localparam int RAND_INSTRS = 1800;
  localparam int IDLE_PCT    = 26;

  class regfile_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] value;
      logic              wr;
    } writeback_t;

    logic [DATA_W-1:0] regs [NREGS];
    writeback_t        pending_writebacks[$];
    int                errors;
    int                checked;
    int                op_seen [16];

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function logic [DATA_W-1:0] fetch(logic [IDX_W-1:0] idx);
      if (idx < NREGS) return regs[idx];
      return '0;
    endfunction

    function void accept_instr(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] d,
                               logic [IDX_W-1:0] sa, logic [IDX_W-1:0] sb,
                               logic [DATA_W-1:0] imm, logic [SH_W-1:0] sh);
      logic [DATA_W-1:0] a, b, v;
      logic              wr;
      writeback_t        wb;
      a  = fetch(sa);
      b  = fetch(sb);
      wr = 1'b1;
      op_seen[f]++;
      case (f)
        rfae_pkg::OP_LI:   v = imm;
        rfae_pkg::OP_ADD:  v = a + b;
        rfae_pkg::OP_ADDI: v = a + imm;
        rfae_pkg::OP_SUB:  v = a - b;
        rfae_pkg::OP_MUL:  v = a * b;
        rfae_pkg::OP_AND:  v = a & b;
        rfae_pkg::OP_OR:   v = a | b;
        rfae_pkg::OP_ORI:  v = a | imm;
        rfae_pkg::OP_XOR:  v = a ^ b;
        rfae_pkg::OP_SLL:  v = a << sh;
        rfae_pkg::OP_SRL:  v = $signed(a) >>> sh;
        default: begin
          v  = fetch(d);
          wr = 1'b0;
        end
      endcase
      if (wr) begin
        if (d < NREGS) regs[d] = v;
        else wr = 1'b0;
      end
      wb.idx   = d;
      wb.value = v;
      wb.wr    = wr;
      pending_writebacks.insert(pending_writebacks.size(), wb);
    endfunction

    function void check_writeback(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                                  logic wr);
      writeback_t exp;
      if (pending_writebacks.size() == 0) begin
        $display("%0t: unexpected transfer idx=%0d value=%h wr=%b",
                 $time, idx, value, wr);
        errors++;
        return;
      end
      exp = pending_writebacks.pop_front();
      checked++;
      if (idx !== exp.idx) begin
        $display("%0t: reg_index expected %0d actual %0d", $time, exp.idx, idx);
        errors++;
      end
      if (value !== exp.value) begin
        $display("%0t: reg_value expected %h actual %h", $time, exp.value, value);
        errors++;
      end
      if (wr !== exp.wr) begin
        $display("%0t: was_write expected %b actual %b", $time, exp.wr, wr);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func;
  logic [IDX_W-1:0]         in_dest_reg;
  logic [IDX_W-1:0]         in_src_a;
  logic [IDX_W-1:0]         in_src_b;
  logic signed [DATA_W-1:0] in_immediate;
  logic [SH_W-1:0]          in_shift_amount;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         out_reg_index;
  logic signed [DATA_W-1:0] out_reg_value;
  logic                     out_was_write;

  regfile_scoreboard sb = new();
  bit                no_idle = 1'b0;
  int                sent    = 0;

  register_file_alu_executor_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_dest_reg     (in_dest_reg),
    .in_src_a        (in_src_a),
    .in_src_b        (in_src_b),
    .in_immediate    (in_immediate),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_was_write   (out_was_write)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_writeback(out_reg_index, out_reg_value, out_was_write);
  end

  task automatic send_instr(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] d,
                            input logic [IDX_W-1:0] sa, input logic [IDX_W-1:0] sb_idx,
                            input logic [DATA_W-1:0] imm, input logic [SH_W-1:0] sh);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_dest_reg     <= d;
    in_src_a        <= sa;
    in_src_b        <= sb_idx;
    in_immediate    <= imm;
    in_shift_amount <= sh;
    do @(posedge clk); while (in_stall);
    sb.accept_instr(f, d, sa, sb_idx, imm, sh);
    sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_imm();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [FUNC_W-1:0] f;
    in_valid        <= 1'b0;
    in_func         <= '0;
    in_dest_reg     <= '0;
    in_src_a        <= '0;
    in_src_b        <= '0;
    in_immediate    <= '0;
    in_shift_amount <= '0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases: extremes, wrap, register 0 and 31, shift limits
    send_instr(rfae_pkg::OP_LI,   5'd1,  5'd0,  5'd0,  32'h7fff_ffff, 5'd0);
    send_instr(rfae_pkg::OP_LI,   5'd2,  5'd0,  5'd0,  32'h8000_0000, 5'd0);
    send_instr(rfae_pkg::OP_LI,   5'd3,  5'd0,  5'd0,  32'hffff_ffff, 5'd0);
    send_instr(rfae_pkg::OP_LI,   5'd0,  5'd0,  5'd0,  32'h0000_0001, 5'd0);
    send_instr(rfae_pkg::OP_ADD,  5'd4,  5'd1,  5'd0,  32'h1234_5678, 5'd31);
    send_instr(rfae_pkg::OP_ADDI, 5'd5,  5'd2,  5'd0,  32'hffff_ffff, 5'd0);
    send_instr(rfae_pkg::OP_SUB,  5'd6,  5'd2,  5'd0,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_MUL,  5'd7,  5'd1,  5'd1,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_MUL,  5'd8,  5'd2,  5'd3,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_AND,  5'd9,  5'd1,  5'd3,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_OR,   5'd10, 5'd2,  5'd0,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_ORI,  5'd11, 5'd0,  5'd0,  32'h8000_0000, 5'd0);
    send_instr(rfae_pkg::OP_XOR,  5'd12, 5'd3,  5'd1,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_SLL,  5'd13, 5'd3,  5'd0,  32'h0,         5'd31);
    send_instr(rfae_pkg::OP_SLL,  5'd14, 5'd1,  5'd0,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_SRL,  5'd15, 5'd2,  5'd0,  32'h0,         5'd31);
    send_instr(rfae_pkg::OP_SRL,  5'd16, 5'd1,  5'd0,  32'h0,         5'd31);
    send_instr(rfae_pkg::OP_SRL,  5'd17, 5'd3,  5'd0,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_READ, 5'd31, 5'd0,  5'd0,  32'h0,         5'd0);
    send_instr(rfae_pkg::OP_LI,   5'd31, 5'd31, 5'd31, 32'h5a5a_5a5a, 5'd31);
    send_instr(rfae_pkg::OP_READ, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 5'd31);
    for (int u = rfae_pkg::OP_READ + 1; u < 16; u++)
      send_instr(FUNC_W'(u), 5'd1, 5'd2, 5'd3, 32'hdead_beef, 5'd7);

    for (int i = 0; i < RAND_INSTRS; i++) begin
      no_idle = (i >= 600 && i < 900);
      if ($urandom_range(15) == 0) f = FUNC_W'($urandom_range(15, rfae_pkg::OP_READ + 1));
      else                         f = FUNC_W'($urandom_range(rfae_pkg::OP_READ));
      send_instr(f, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                 pick_imm(), SH_W'($urandom));
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    for (int w = 0; w < 10000 && sb.pending_writebacks.size() != 0; w++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending_writebacks.size() != 0) begin
      $display("%0t: %0d writebacks never arrived", $time, sb.pending_writebacks.size());
      sb.errors += sb.pending_writebacks.size();
    end

    $display("%0d instructions sent, %0d writebacks compared", sent, sb.checked);
    $display("per-func counts li..read: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3], sb.op_seen[4],
             sb.op_seen[5], sb.op_seen[6], sb.op_seen[7], sb.op_seen[8], sb.op_seen[9],
             sb.op_seen[10], sb.op_seen[11]);
    if (sb.errors == 0)
      $display("register_file_alu_executor_unit: match");
    else
      $display("register_file_alu_executor_unit: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("register_file_alu_executor_unit: mismatch");
    $finish;
  end

endmodule

@@ register_file_alu_executor_unit.f @@
rtl/rfae_pkg.sv
rtl/rfae_front.sv
rtl/rfae_queue.sv
rtl/rfae_back.sv
rtl/register_file_alu_executor_unit.sv
dv/tb_register_file_alu_executor_unit.sv
